[hdl/x86e_pkg.sv]
// ----------------------------------------------------------------------------
// x86e_pkg: shared types and constants of the instruction byte encoder
// Request and byte beat structs, the decoded instruction record, opcode
// tables and kind codes.
// ----------------------------------------------------------------------------
package x86e_pkg;

  localparam int unsigned MaxBytes = 10;
  localparam int unsigned CntW     = 4;

  typedef struct packed {
    logic [5:0]         req_type;
    logic [3:0]         first_reg;
    logic [3:0]         second_reg;
    logic [63:0]        immediate;
    logic signed [31:0] displacement;
  } req_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } byte_t;

  // Decoded instruction: up to ten bytes and a byte count.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
  } insn_t;

  localparam logic [5:0] KindImul   = 6'd4;
  localparam logic [5:0] KindMovI64 = 6'd8;
  localparam logic [5:0] KindMovI32 = 6'd9;
  localparam logic [5:0] KindShlI   = 6'd23;
  localparam logic [5:0] KindShrI   = 6'd24;
  localparam logic [5:0] KindLoad   = 6'd27;
  localparam logic [5:0] KindStore  = 6'd28;
  localparam logic [5:0] KindPush   = 6'd29;
  localparam logic [5:0] KindPop    = 6'd30;
  localparam logic [5:0] KindJmp    = 6'd31;
  localparam logic [5:0] KindJz     = 6'd32;
  localparam logic [5:0] KindJnz    = 6'd33;
  localparam logic [5:0] KindCall   = 6'd34;
  localparam logic [5:0] KindRet    = 6'd35;
  localparam logic [5:0] KindNop    = 6'd36;
  localparam logic [5:0] KindInt3   = 6'd37;

  localparam logic [7:0] RexPlain = 8'h40;
  localparam logic [7:0] RexW     = 8'h08;
  localparam logic [7:0] RexR     = 8'h04;
  localparam logic [7:0] RexB     = 8'h01;

  localparam logic [7:0][7:0] RrOpcode =
    {8'h31, 8'h09, 8'h21, 8'hAF, 8'h39, 8'h29, 8'h01, 8'h89};
  localparam logic [7:0][2:0] Imm32Ext =
    {3'd6, 3'd1, 3'd4, 3'd7, 3'd5, 3'd0, 3'd0, 3'd0};
  localparam logic [10:0][7:0] UnaryOp =
    {8'hD3, 8'hD3, 8'hC1, 8'hC1, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hFF, 8'hFF};
  localparam logic [10:0][2:0] UnaryExt =
    {3'd5, 3'd4, 3'd5, 3'd4, 3'd7, 3'd6, 3'd4, 3'd2, 3'd3, 3'd1, 3'd0};

endpackage

[hdl/x86e_front.sv]
// ----------------------------------------------------------------------------
// x86e_front: request decoder
// Classify one request and lay out all its bytes; register the record.
// ----------------------------------------------------------------------------
module x86e_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  x86e_pkg::req_t  req_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output x86e_pkg::insn_t insn_o,
  output logic            insn_valid_o,
  input  logic            insn_ready_i
);

  x86e_pkg::insn_t insn_d, insn_q;
  logic            valid_q;

  logic [9:0][7:0] b;
  logic [3:0]      n;

  function automatic logic [7:0] rex_w(logic [3:0] r, logic [3:0] bb);
    rex_w = x86e_pkg::RexPlain | x86e_pkg::RexW | (r[3] ? x86e_pkg::RexR : 8'h00)
          | (bb[3] ? x86e_pkg::RexB : 8'h00);
  endfunction

  function automatic logic [7:0] modrm(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
    modrm = {md, rg, rm};
  endfunction

  always_comb begin
    logic [5:0]  k;
    logic [3:0]  d, s;
    logic [31:0] disp;
    logic        zero_mode, short_disp;
    logic [1:0]  md;
    logic [3:0]  p;
    logic [3:0]  uk;
    k    = req_i.req_type;
    d    = req_i.first_reg;
    s    = req_i.second_reg;
    disp = req_i.displacement;
    b    = '0;
    n    = '0;
    zero_mode  = (disp == 32'd0) && (s[2:0] != 3'd5);
    short_disp = ((disp + 32'h80) < 32'h100);
    md   = zero_mode ? 2'd0 : (short_disp ? 2'd1 : 2'd2);
    uk   = 4'(k - 6'd16);
    p    = '0;
    if (k < 6'd8) begin
      if (k == x86e_pkg::KindImul) begin
        b[0] = rex_w(d, s);
        b[1] = 8'h0F;
        b[2] = 8'hAF;
        b[3] = modrm(2'd3, d[2:0], s[2:0]);
        n    = 4'd4;
      end else begin
        b[0] = rex_w(s, d);
        b[1] = x86e_pkg::RrOpcode[k[2:0]];
        b[2] = modrm(2'd3, s[2:0], d[2:0]);
        n    = 4'd3;
      end
    end else if (k == x86e_pkg::KindMovI64) begin
      b[0] = rex_w(4'd0, d);
      b[1] = 8'hB8 + {5'd0, d[2:0]};
      for (int i = 0; i < 8; i++) b[2+i] = req_i.immediate[8*i +: 8];
      n = 4'd10;
    end else if (k < 6'd16) begin
      b[0] = rex_w(4'd0, d);
      b[1] = (k == x86e_pkg::KindMovI32) ? 8'hC7 : 8'h81;
      b[2] = modrm(2'd3, x86e_pkg::Imm32Ext[k[2:0]], d[2:0]);
      for (int i = 0; i < 4; i++) b[3+i] = req_i.immediate[8*i +: 8];
      n = 4'd7;
    end else if (k < 6'd27) begin
      b[0] = rex_w(4'd0, d);
      b[1] = x86e_pkg::UnaryOp[uk];
      b[2] = modrm(2'd3, x86e_pkg::UnaryExt[uk], d[2:0]);
      b[3] = {3'd0, req_i.immediate[4:0]};
      n = (k == x86e_pkg::KindShlI || k == x86e_pkg::KindShrI) ? 4'd4 : 4'd3;
    end else begin
      case (k)
        x86e_pkg::KindLoad, x86e_pkg::KindStore: begin
          b[0] = rex_w(d, s);
          b[1] = (k == x86e_pkg::KindLoad) ? 8'h8B : 8'h89;
          b[2] = modrm(md, d[2:0], s[2:0]);
          p = 4'd3;
          if (s[2:0] == 3'd4) begin
            b[3] = 8'h24;
            p = 4'd4;
          end
          if (!zero_mode) begin
            for (int i = 0; i < 4; i++) b[p + 4'(i)] = disp[8*i +: 8];
            p = p + (short_disp ? 4'd1 : 4'd4);
          end
          n = p;
        end
        x86e_pkg::KindPush, x86e_pkg::KindPop: begin
          if (d[3]) begin
            b[0] = x86e_pkg::RexPlain | x86e_pkg::RexB;
            b[1] = ((k == x86e_pkg::KindPush) ? 8'h50 : 8'h58) + {5'd0, d[2:0]};
            n = 4'd2;
          end else begin
            b[0] = ((k == x86e_pkg::KindPush) ? 8'h50 : 8'h58) + {5'd0, d[2:0]};
            n = 4'd1;
          end
        end
        x86e_pkg::KindJmp, x86e_pkg::KindCall: begin
          b[0] = (k == x86e_pkg::KindJmp) ? 8'hE9 : 8'hE8;
          for (int i = 0; i < 4; i++) b[1+i] = disp[8*i +: 8];
          n = 4'd5;
        end
        x86e_pkg::KindJz, x86e_pkg::KindJnz: begin
          b[0] = 8'h0F;
          b[1] = (k == x86e_pkg::KindJz) ? 8'h84 : 8'h85;
          for (int i = 0; i < 4; i++) b[2+i] = disp[8*i +: 8];
          n = 4'd6;
        end
        x86e_pkg::KindRet:  begin b[0] = 8'hC3; n = 4'd1; end
        x86e_pkg::KindNop:  begin b[0] = 8'h90; n = 4'd1; end
        x86e_pkg::KindInt3: begin b[0] = 8'hCC; n = 4'd1; end
        default: n = '0;
      endcase
    end
    insn_d.bytes = b;
    insn_d.count = n;
  end

  // Unused kinds produce nothing: drop them here.
  assign req_ready_o  = !valid_q || insn_ready_i;
  assign insn_o       = insn_q;
  assign insn_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_ready_o) begin
      valid_q <= req_valid_i && (insn_d.count != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o) begin
      insn_q <= insn_d;
    end
  end

  property p_count_range;
    @(posedge clk_i) disable iff (!rst_ni)
      valid_q |-> (insn_q.count != '0 && insn_q.count <= 4'(x86e_pkg::MaxBytes));
  endproperty
  a_count_range: assert property (p_count_range) else $error("bad byte count");

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_q && !insn_ready_i) |=> (valid_q && $stable(insn_q));
  endproperty
  a_hold: assert property (p_hold) else $error("decoded record lost");

  property p_mov64;
    @(posedge clk_i) disable iff (!rst_ni)
      (req_valid_i && req_ready_o && req_i.req_type == x86e_pkg::KindMovI64)
        |=> (insn_q.count == 4'd10);
  endproperty
  a_mov64: assert property (p_mov64) else $error("imm64 length wrong");

endmodule

[hdl/x86e_fifo.sv]
// ----------------------------------------------------------------------------
// x86e_fifo: two-entry record queue
// Decouple the decoder from the byte emitter.
// ----------------------------------------------------------------------------
module x86e_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  x86e_pkg::insn_t wdata_i,
  input  logic            wvalid_i,
  output logic            wready_o,
  output x86e_pkg::insn_t rdata_o,
  output logic            rvalid_o,
  input  logic            rready_i
);

  x86e_pkg::insn_t mem_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            wr, rd;

  assign wready_o = cnt_q != 2'd2;
  assign rvalid_o = cnt_q != 2'd0;
  assign rdata_o  = mem_q[rptr_q];
  assign wr = wvalid_i && wready_o;
  assign rd = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= !wptr_q;
      if (rd) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_count_track;
    @(posedge clk_i) disable iff (!rst_ni)
      (wr && !rd) |=> (cnt_q == $past(cnt_q) + 2'd1);
  endproperty
  a_count_track: assert property (p_count_track) else $error("queue count slip");

  property p_pointer_gap;
    @(posedge clk_i) disable iff (!rst_ni)
      (cnt_q == 2'd1) |-> (wptr_q != rptr_q);
  endproperty
  a_pointer_gap: assert property (p_pointer_gap) else $error("pointer mismatch");

endmodule

[hdl/x86e_back.sv]
// ----------------------------------------------------------------------------
// x86e_back: byte emitter
// Walk one record byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module x86e_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  x86e_pkg::insn_t insn_i,
  input  logic            insn_valid_i,
  output logic            insn_ready_o,
  output x86e_pkg::byte_t beat_o,
  output logic            empty,
  input  logic            pop
);

  logic [x86e_pkg::CntW-1:0] idx_q;
  logic                      ovalid_q;
  x86e_pkg::byte_t           beat_q;
  logic                      load, last;

  assign load         = insn_valid_i && (!ovalid_q || pop);
  assign last         = (idx_q + 4'd1) == insn_i.count;
  assign insn_ready_o = load && last;
  assign beat_o       = beat_q;
  assign empty        = !ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        ovalid_q <= 1'b1;
        idx_q    <= last ? '0 : idx_q + 4'd1;
      end else if (pop) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q.code_byte <= insn_i.bytes[idx_q];
      beat_q.last_byte <= last;
    end
  end

  property p_idx_range;
    @(posedge clk_i) disable iff (!rst_ni)
      insn_valid_i |-> (idx_q < insn_i.count);
  endproperty
  a_idx_range: assert property (p_idx_range) else $error("byte index overrun");

  property p_idx_reset;
    @(posedge clk_i) disable iff (!rst_ni) insn_ready_o |=> (idx_q == '0);
  endproperty
  a_idx_reset: assert property (p_idx_reset) else $error("index not cleared");

  property p_last_done;
    @(posedge clk_i) disable iff (!rst_ni)
      (load && last) |=> beat_q.last_byte;
  endproperty
  a_last_done: assert property (p_last_done) else $error("last mark missing");

endmodule

[hdl/x86_64_instruction_byte_encoder.sv]
// ----------------------------------------------------------------------------
// x86_64_instruction_byte_encoder: x86-64 machine code emitter
// Turn one instruction request into its REX/opcode/ModRM/SIB/disp/imm bytes.
// ----------------------------------------------------------------------------
//  channel | ports                        | handshake
//  request | req_i (x86e_pkg::req_t)      | push, full
//  bytes   | beat_o (x86e_pkg::byte_t)    | pop, empty
//
// One request per cycle enters the decoder while full is low; the emitter then
// sends one byte beat per cycle unless pop stalls, 1..10 beats per request.
// Throughput is set by the emitter's single output byte port.
// Reset clears valid flags, pointers and counters only; no clearing pass.
// A stall on pop holds the output beat; the two-entry queue absorbs it.
// Unused kinds are dropped in the decoder and produce no beat.
// ----------------------------------------------------------------------------
module x86_64_instruction_byte_encoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  x86e_pkg::req_t  req_i,
  input  logic            push,
  output logic            full,
  output x86e_pkg::byte_t beat_o,
  output logic            empty,
  input  logic            pop
);

  x86e_pkg::insn_t dec_insn, q_insn;
  logic dec_valid, dec_ready, q_valid, q_ready, ready;

  // Accept a request whenever the decoder stage can advance.
  assign full = !ready;

  x86e_front u_front (
    .clk_i, .rst_ni,
    .req_i,
    .req_valid_i  (push),
    .req_ready_o  (ready),
    .insn_o       (dec_insn),
    .insn_valid_o (dec_valid),
    .insn_ready_i (dec_ready)
  );

  x86e_fifo u_fifo (
    .clk_i, .rst_ni,
    .wdata_i  (dec_insn),
    .wvalid_i (dec_valid),
    .wready_o (dec_ready),
    .rdata_o  (q_insn),
    .rvalid_o (q_valid),
    .rready_i (q_ready)
  );

  x86e_back u_back (
    .clk_i, .rst_ni,
    .insn_i       (q_insn),
    .insn_valid_i (q_valid),
    .insn_ready_o (q_ready),
    .beat_o,
    .empty,
    .pop
  );

endmodule

[dv/x86_64_instruction_byte_encoder_tb.sv]
// ----------------------------------------------------------------------------
// x86_64_instruction_byte_encoder_tb: self-checking bench for the byte encoder
// Sends directed and random instruction requests through the push/full side,
// predicts each byte beat and checks it on the pop/empty side. Both sides
// idle at random; the receiver also holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module x86_64_instruction_byte_encoder_tb;

  localparam int unsigned NumRandom  = 500;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 40;

  // Kind groups that the package does not name.
  localparam logic [5:0] KindMovRr  = 6'd0;
  localparam logic [5:0] KindImmLo  = 6'd8;
  localparam logic [5:0] KindXorI   = 6'd15;
  localparam logic [5:0] KindUnaLo  = 6'd16;
  localparam logic [5:0] KindUnaHi  = 6'd26;
  localparam logic [5:0] KindUnused = 6'd38;
  localparam logic [5:0] KindTop    = 6'd63;

  logic             clk_i;
  logic             rst_ni;
  x86e_pkg::req_t   req_i;
  logic             push;
  logic             full;
  x86e_pkg::byte_t  beat_o;
  logic             empty;
  logic             pop;

  x86_64_instruction_byte_encoder dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .push  (push),
    .full  (full),
    .beat_o(beat_o),
    .empty (empty),
    .pop   (pop)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Expected byte beats, oldest first.
  x86e_pkg::byte_t code_q[$];
  int unsigned     mismatches = 0;
  int unsigned     idle_cycles = 0;
  bit              stim_done = 1'b0;
  bit              no_idle = 1'b0;   // long stretch without idling
  bit              hold_pop = 1'b0;  // long receiver hold-off

  // Directed rows: request and, where obvious, the bytes to expect.
  typedef struct {
    x86e_pkg::req_t req;
    bit             typed;
    logic [7:0]     bytes[$];
  } row_t;
  row_t rows[$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH %s at %0t", what, $realtime);
    mismatches++;
  endtask

  // Byte builders for the encoding predictor.
  function automatic logic [7:0] rex_w(input logic [3:0] r, input logic [3:0] b);
    return x86e_pkg::RexPlain | x86e_pkg::RexW | (r[3] ? x86e_pkg::RexR : 8'h00)
         | (b[3] ? x86e_pkg::RexB : 8'h00);
  endfunction

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                       input logic [2:0] rm);
    return {md, rg, rm};
  endfunction

  // Work out the machine code of one request.
  function automatic void encode_insn(input x86e_pkg::req_t r, ref logic [7:0] o[$]);
    logic [5:0]  k;
    logic [3:0]  d;
    logic [3:0]  s;
    logic [31:0] disp;
    logic [31:0] imm32;
    bit          zero_mode;
    bit          short_disp;
    logic [3:0]  u;
    k = r.req_type; d = r.first_reg; s = r.second_reg;
    disp = r.displacement; imm32 = r.immediate[31:0];
    o = {};
    if (k < KindImmLo) begin
      if (k == x86e_pkg::KindImul) begin
        o = '{rex_w(d, s), 8'h0F, 8'hAF, modrm(2'd3, d[2:0], s[2:0])};
      end else begin
        o = '{rex_w(s, d), x86e_pkg::RrOpcode[k[2:0]], modrm(2'd3, s[2:0], d[2:0])};
      end
    end else if (k == x86e_pkg::KindMovI64) begin
      o = '{rex_w(4'd0, d), 8'hB8 + {5'd0, d[2:0]}};
      for (int i = 0; i < 8; i++) o.insert(o.size(), r.immediate[8*i +: 8]);
    end else if (k < KindUnaLo) begin
      o = '{rex_w(4'd0, d), (k == x86e_pkg::KindMovI32) ? 8'hC7 : 8'h81,
            modrm(2'd3, x86e_pkg::Imm32Ext[k[2:0]], d[2:0])};
      for (int i = 0; i < 4; i++) o.insert(o.size(), imm32[8*i +: 8]);
    end else if (k <= KindUnaHi) begin
      u = 4'(k - KindUnaLo);
      o = '{rex_w(4'd0, d), x86e_pkg::UnaryOp[u],
            modrm(2'd3, x86e_pkg::UnaryExt[u], d[2:0])};
      if (k == x86e_pkg::KindShlI || k == x86e_pkg::KindShrI)
        o.insert(o.size(), {3'b000, r.immediate[4:0]});
    end else begin
      case (k)
        x86e_pkg::KindLoad, x86e_pkg::KindStore: begin
          zero_mode  = (disp == 0) && (s[2:0] != 3'd5);
          short_disp = (disp + 32'h80) < 32'h100;
          o = '{rex_w(d, s), (k == x86e_pkg::KindLoad) ? 8'h8B : 8'h89};
          o.insert(o.size(), modrm(zero_mode ? 2'd0 : (short_disp ? 2'd1 : 2'd2),
                                   d[2:0], s[2:0]));
          if (s[2:0] == 3'd4) o.insert(o.size(), 8'h24);
          if (!zero_mode) begin
            for (int i = 0; i < (short_disp ? 1 : 4); i++)
              o.insert(o.size(), disp[8*i +: 8]);
          end
        end
        x86e_pkg::KindPush, x86e_pkg::KindPop: begin
          if (d[3]) o.insert(o.size(), x86e_pkg::RexPlain | x86e_pkg::RexB);
          o.insert(o.size(), ((k == x86e_pkg::KindPush) ? 8'h50 : 8'h58) + {5'd0, d[2:0]});
        end
        x86e_pkg::KindJmp, x86e_pkg::KindCall, x86e_pkg::KindJz, x86e_pkg::KindJnz: begin
          if (k == x86e_pkg::KindJmp) o.insert(o.size(), 8'hE9);
          else if (k == x86e_pkg::KindCall) o.insert(o.size(), 8'hE8);
          else o = '{8'h0F, (k == x86e_pkg::KindJz) ? 8'h84 : 8'h85};
          for (int i = 0; i < 4; i++) o.insert(o.size(), disp[8*i +: 8]);
        end
        x86e_pkg::KindRet:  o.insert(o.size(), 8'hC3);
        x86e_pkg::KindNop:  o.insert(o.size(), 8'h90);
        x86e_pkg::KindInt3: o.insert(o.size(), 8'hCC);
        default: ;
      endcase
    end
  endfunction

  function automatic x86e_pkg::req_t mk(input logic [5:0] k, input logic [3:0] d,
                                        input logic [3:0] s, input logic [63:0] imm,
                                        input logic [31:0] disp);
    x86e_pkg::req_t r;
    r.req_type = k; r.first_reg = d; r.second_reg = s;
    r.immediate = imm; r.displacement = disp;
    return r;
  endfunction

  function automatic void add_row(input x86e_pkg::req_t r, input bit typed,
                                  input logic [7:0] b[$]);
    row_t w;
    w.req = r; w.typed = typed; w.bytes = b;
    rows.insert(rows.size(), w);
  endfunction

  function automatic x86e_pkg::req_t rand_req();
    x86e_pkg::req_t r;
    r.req_type   = 6'((($urandom_range(0, 19) == 0) ? $urandom_range(KindUnused, KindTop)
                                                    : $urandom_range(0, x86e_pkg::KindInt3)));
    r.first_reg  = 4'($urandom());
    r.second_reg = 4'($urandom());
    r.immediate  = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: r.displacement = 0;
      1: r.displacement = $urandom_range(0, 255) - 128;
      2: r.displacement = ($urandom_range(0, 1) ? 32'sd128 : -32'sd129);
      default: r.displacement = $urandom();
    endcase
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 22);
  endfunction

  // Offer one request, hold it until accepted, then queue its bytes.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input x86e_pkg::req_t r, input bit typed,
                          input logic [7:0] want[$]);
    logic [7:0]      pred[$];
    x86e_pkg::byte_t bt;
    while (idle_now()) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    encode_insn(r, pred);
    if (typed && pred != want)
      report_mismatch($sformatf("predictor disagrees with typed row, kind %0d",
                                r.req_type));
    req_i <= r;
    push  <= 1'b1;
    do @(posedge clk_i); while (full);
    foreach (pred[i]) begin
      bt.code_byte = pred[i];
      bt.last_byte = (i == pred.size() - 1);
      code_q.insert(code_q.size(), bt);
    end
    @(negedge clk_i);
  endtask

  // Sender.
  initial begin
    x86e_pkg::req_t r;
    push   = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, every kind group, memory mode corner cases.
    add_row(mk(KindMovRr, 4'd0, 4'd0, '0, 0), 1, '{8'h48, 8'h89, 8'hC0});
    add_row(mk(KindMovRr, 4'd15, 4'd15, '0, 0), 1, '{8'h4D, 8'h89, 8'hFF});
    add_row(mk(x86e_pkg::KindImul, 4'd9, 4'd2, '1, -1), 1,
            '{8'h4C, 8'h0F, 8'hAF, 8'hCA});
    add_row(mk(x86e_pkg::KindMovI64, 4'd15, 4'd0, 64'hFFEEDDCCBBAA9988, 0), 1,
            '{8'h49, 8'hBF, 8'h88, 8'h99, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE, 8'hFF});
    add_row(mk(x86e_pkg::KindMovI32, 4'd0, 4'd0, 64'hFFFFFFFF_12345678, 0), 1,
            '{8'h48, 8'hC7, 8'hC0, 8'h78, 8'h56, 8'h34, 8'h12});
    add_row(mk(KindXorI, 4'd12, 4'd3, '1, 0), 0, '{});
    add_row(mk(KindUnaLo, 4'd0, 4'd0, '0, 0), 1, '{8'h48, 8'hFF, 8'hC0});
    add_row(mk(x86e_pkg::KindShlI, 4'd1, 4'd0, 64'hFF, 0), 1,
            '{8'h48, 8'hC1, 8'hE1, 8'h1F});
    add_row(mk(x86e_pkg::KindShrI, 4'd8, 4'd0, 64'h20, 0), 0, '{});
    add_row(mk(KindUnaHi, 4'd14, 4'd0, '0, 0), 0, '{});
    add_row(mk(x86e_pkg::KindLoad, 4'd0, 4'd0, '0, 0), 1, '{8'h48, 8'h8B, 8'h00});
    add_row(mk(x86e_pkg::KindLoad, 4'd0, 4'd5, '0, 0), 1,
            '{8'h48, 8'h8B, 8'h45, 8'h00});
    add_row(mk(x86e_pkg::KindLoad, 4'd0, 4'd13, '0, 127), 0, '{});
    add_row(mk(x86e_pkg::KindStore, 4'd15, 4'd4, '0, 0), 1,
            '{8'h4C, 8'h89, 8'h3C, 8'h24});
    add_row(mk(x86e_pkg::KindStore, 4'd2, 4'd12, '0, -128), 0, '{});
    add_row(mk(x86e_pkg::KindLoad, 4'd7, 4'd3, '0, 128), 0, '{});
    add_row(mk(x86e_pkg::KindStore, 4'd3, 4'd4, '0, 32'h80000000), 0, '{});
    add_row(mk(x86e_pkg::KindPush, 4'd0, 4'd0, '0, 0), 1, '{8'h50});
    add_row(mk(x86e_pkg::KindPop, 4'd15, 4'd0, '0, 0), 1, '{8'h41, 8'h5F});
    add_row(mk(x86e_pkg::KindJmp, 4'd0, 4'd0, '0, 32'h7FFFFFFF), 1,
            '{8'hE9, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
    add_row(mk(x86e_pkg::KindJz, 4'd0, 4'd0, '0, -1), 0, '{});
    add_row(mk(x86e_pkg::KindJnz, 4'd0, 4'd0, '0, 1), 0, '{});
    add_row(mk(x86e_pkg::KindCall, 4'd0, 4'd0, '0, 0), 0, '{});
    add_row(mk(x86e_pkg::KindRet, 4'd0, 4'd0, '0, 0), 1, '{8'hC3});
    add_row(mk(KindUnused, 4'd0, 4'd0, '0, 0), 1, '{});
    add_row(mk(KindTop, 4'd15, 4'd15, '1, -1), 1, '{});
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].bytes);
    add_row(mk(x86e_pkg::KindNop, 4'd0, 4'd0, '0, 0), 1, '{8'h90});
    add_row(mk(x86e_pkg::KindInt3, 4'd0, 4'd0, '0, 0), 1, '{8'hCC});
    send_req(rows[rows.size()-2].req, 1, rows[rows.size()-2].bytes);
    send_req(rows[rows.size()-1].req, 1, rows[rows.size()-1].bytes);

    // Drop push, then pause until every expected beat has drained.
    push <= 1'b0;
    wait (code_q.size() == 0);
    @(negedge clk_i);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 100) hold_pop = 1'b1;
      no_idle = (n >= 300 && n < 380);
      r = rand_req();
      send_req(r, 0, '{});
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random pop, with one long hold-off.
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_pop = 1'b0;
      end
      pop <= !idle_now();
    end
  end

  // Check each accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    x86e_pkg::byte_t want;
    if (rst_ni && pop && !empty) begin
      if (code_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", beat_o.code_byte));
      end else begin
        want = code_q.pop_front();
        if (beat_o.code_byte !== want.code_byte)
          report_mismatch($sformatf("code_byte: got %h, expected %h",
                                    beat_o.code_byte, want.code_byte));
        if (beat_o.last_byte !== want.last_byte)
          report_mismatch($sformatf("last_byte: got %b, expected %b",
                                    beat_o.last_byte, want.last_byte));
      end
    end
  end

  // Watchdog: count cycles with no beat moving on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // End of run: drain, then let the block settle.
  initial begin
    wait (stim_done);
    wait (code_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && code_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
hdl/x86e_pkg.sv
hdl/x86e_front.sv
hdl/x86e_fifo.sv
hdl/x86e_back.sv
hdl/x86_64_instruction_byte_encoder.sv
dv/x86_64_instruction_byte_encoder_tb.sv
